// ===== rtl/core/idft_pkg.sv =====
`timescale 1ns / 1ps

package idft_pkg;

  localparam int POINTS      = 1024;
  localparam int PTS_W       = $clog2(POINTS);
  localparam int SMP_W       = 16;
  localparam int OUT_W       = 17;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = 2 * SMP_W;
  localparam int TW_W        = 2 * SMP_W;
  localparam int ROUND_SHIFT = PTS_W + 15;
  localparam int QDEPTH      = 2;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(65535);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(65536);

  typedef struct packed {
    logic                    req_type;
    logic [PTS_W-1:0]        position;
    logic signed [SMP_W-1:0] sample_re;
    logic signed [SMP_W-1:0] sample_im;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND
  } back_st_t;

  typedef logic [TW_W-1:0] tw_rom_t [POINTS];

  localparam int     CORDIC_STEPS = 30;
  localparam longint CORDIC_GAIN  = 64'sh26DD3B6A;
  localparam longint Q30_ONE      = 64'sh40000000;
  localparam longint HALF_TURN    = 64'sh80000000;
  localparam longint HALF_POINTS  = POINTS / 2;

  localparam longint ARC_STEP [CORDIC_STEPS] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4, 64'sh028B0D43,
    64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55, 64'sh0028BE53, 64'sh00145F2F,
    64'sh000A2F98, 64'sh000517CC, 64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA,
    64'sh0000517D, 64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
    64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051, 64'sh00000029,
    64'sh00000014, 64'sh0000000A, 64'sh00000005, 64'sh00000003, 64'sh00000001
  };

  function automatic logic [SMP_W-1:0] to_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return r[SMP_W-1:0];
  endfunction

  // Each entry holds cos in the upper half and sin in the lower half, Q1.15.
  function automatic tw_rom_t build_tw();
    tw_rom_t t;
    longint  ph;
    longint  z;
    longint  x;
    longint  y;
    longint  dx;
    longint  dy;
    bit      flip;
    for (int m = 0; m < POINTS; m++) begin
      ph   = ((longint'(m) <<< 32) + HALF_POINTS) >>> PTS_W;
      z    = longint'(signed'(ph[31:0]));
      x    = CORDIC_GAIN;
      y    = 64'sd0;
      flip = 1'b0;
      if (z > Q30_ONE) begin
        z    = z - HALF_TURN;
        flip = 1'b1;
      end else if (z < -Q30_ONE) begin
        z    = z + HALF_TURN;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 64'sd0) begin
          x = x - dx;
          y = y + dy;
          z = z - ARC_STEP[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ARC_STEP[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      t[m] = {to_q15(x), to_q15(y)};
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/idft_front.sv =====
`timescale 1ns / 1ps

module idft_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [idft_pkg::PTS_W-1:0]      position,
  input  logic signed [idft_pkg::SMP_W-1:0] sample_re,
  input  logic signed [idft_pkg::SMP_W-1:0] sample_im,
  output logic                            q_valid,
  output idft_pkg::item_t                 q_item,
  input  logic                            q_pop
);
  import idft_pkg::*;

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign busy    = (count == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign pop     = q_pop && q_valid;
  assign q_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{req_type:  req_type,
                           position:  position,
                           sample_re: sample_re,
                           sample_im: sample_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/idft_tw_rom.sv =====
`timescale 1ns / 1ps

module idft_tw_rom (
  input  logic                        clk,
  input  logic [idft_pkg::PTS_W-1:0]  addr,
  output logic [idft_pkg::TW_W-1:0]   data
);
  import idft_pkg::*;

  localparam tw_rom_t TW_TABLE = build_tw();

  always_ff @(posedge clk) begin
    data <= TW_TABLE[addr];
  end

endmodule

// ===== rtl/core/idft_back.sv =====
`timescale 1ns / 1ps

module idft_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  idft_pkg::item_t                   q_item,
  output logic                              q_pop,
  output logic                              done,
  output logic [idft_pkg::PTS_W-1:0]        out_position,
  output logic signed [idft_pkg::OUT_W-1:0] real_value
);
  import idft_pkg::*;

  back_st_t                 state;
  back_st_t                 state_next;
  logic                     mem_we;
  logic                     start_run;
  logic                     issue;
  logic [TW_W-1:0]          samples [POINTS];
  logic [TW_W-1:0]          smp_rd;
  logic [TW_W-1:0]          tw_rd;
  logic [PTS_W-1:0]         k;
  logic [PTS_W-1:0]         m;
  logic [PTS_W-1:0]         n;
  logic                     rd_v;
  logic                     mul_v;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  num;
  logic signed [ACC_W-1:0]  quo;
  logic signed [OUT_W-1:0]  sat;

  idft_tw_rom u_tw_rom (
    .clk  (clk),
    .addr (m),
    .data (tw_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    start_run  = 1'b0;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.req_type == REQ_READ) begin
            start_run  = 1'b1;
            state_next = ST_RUN;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (k == PTS_W'(POINTS - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v && !mul_v) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      samples[q_item.position] <= {q_item.sample_re, q_item.sample_im};
    end
    smp_rd <= samples[k];
  end

  always_ff @(posedge clk) begin
    if (start_run) begin
      k <= '0;
      m <= '0;
      n <= q_item.position;
    end else if (issue) begin
      k <= k + PTS_W'(1);
      m <= m + n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    prod_re <= $signed(smp_rd[TW_W-1:SMP_W]) * $signed(tw_rd[TW_W-1:SMP_W]);
    prod_im <= $signed(smp_rd[SMP_W-1:0]) * $signed(tw_rd[SMP_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (start_run) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod_re) - ACC_W'(prod_im);
    end
  end

  // The divisor is a power of two, so rounding half up is an offset and a floor shift.
  always_comb begin
    num = acc + (ACC_W'(1) <<< (ROUND_SHIFT - 1));
    quo = num >>> ROUND_SHIFT;
    if (quo > OUT_MAX) begin
      sat = OUT_MAX[OUT_W-1:0];
    end else if (quo < OUT_MIN) begin
      sat = OUT_MIN[OUT_W-1:0];
    end else begin
      sat = quo[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND) begin
      real_value   <= sat;
      out_position <= n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_ROUND);
    end
  end

endmodule

// ===== rtl/core/inverse_dft_real_part.sv =====
`timescale 1ns / 1ps

// Direct inverse DFT that returns the real part at one output index per read.
// A request is transferred at a rising edge where start is high and busy is low.
// With req_type low the request stores sample_re and sample_im at position.
// With req_type high it computes the output at index position.
// Requests enter a two-entry queue in order, and busy is high while it is full.
// A load is taken from the queue and written to the sample store by the back end.
// A read holds the back end while it is taken from the queue, runs through a single
// complex multiply-accumulate over all 1024 points, drains the pipeline and is rounded.
// The result is registered from the rounding state onto the outputs.
// The back end takes no new request from the queue until a read has been rounded.
// A result is shown on out_position and real_value for exactly one cycle,
// marked by done, and is transferred at the edge that ends that cycle.
// The receiver cannot stall, so results are never held back.
// Reset clears the queue and the sequencer but not the sample store.
// A read must only use positions that were loaded since power-up.
module inverse_dft_real_part (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic [idft_pkg::PTS_W-1:0]        position,
  input  logic signed [idft_pkg::SMP_W-1:0] sample_re,
  input  logic signed [idft_pkg::SMP_W-1:0] sample_im,
  output logic                              done,
  output logic [idft_pkg::PTS_W-1:0]        out_position,
  output logic signed [idft_pkg::OUT_W-1:0] real_value
);
  import idft_pkg::*;

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  idft_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .position  (position),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  idft_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .done         (done),
    .out_position (out_position),
    .real_value   (real_value)
  );

endmodule

// ===== tb/tb_inverse_dft_real_part.sv =====
`timescale 1ns / 1ps

module tb_inverse_dft_real_part;
  import idft_pkg::*;

  localparam int          RANDOM_ITEMS = 580;
  localparam int          CALM_TAIL    = 100;
  localparam int          DRAIN_CYCLES = 1100;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int          ROT_STEPS    = 30;
  localparam longint      ROT_GAIN_Q30 = 64'sh26DD3B6A;
  localparam longint      QUARTER_TURN = 64'sh40000000;
  localparam longint      HALF_TURN_Q  = 64'sh80000000;
  localparam longint      FULL_TURN_Q  = 64'sh100000000;

  localparam longint cordic_arc [ROT_STEPS] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4, 64'sh028B0D43,
    64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55, 64'sh0028BE53, 64'sh00145F2F,
    64'sh000A2F98, 64'sh000517CC, 64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA,
    64'sh0000517D, 64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
    64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051, 64'sh00000029,
    64'sh00000014, 64'sh0000000A, 64'sh00000005, 64'sh00000003, 64'sh00000001
  };

  typedef struct {
    logic [PTS_W-1:0]        pos;
    logic signed [OUT_W-1:0] val;
  } idft_output_t;

  typedef struct {
    logic                    rt;
    logic [PTS_W-1:0]        pos;
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    bit                      typed;
    logic signed [OUT_W-1:0] val;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 16;

  stim_row_t directed [DIRECTED_ROWS] = '{
    '{REQ_READ, 10'd0,    16'sh0000, 16'sh0000, 1'b1, 17'sd0},
    '{REQ_READ, 10'd1023, 16'sh0000, 16'sh0000, 1'b1, 17'sd0},
    '{REQ_LOAD, 10'd0,    16'sh7FFF, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_READ, 10'd0,    16'sh0000, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_LOAD, 10'd1023, 16'sh8000, 16'sh8000, 1'b0, 17'sd0},
    '{REQ_LOAD, 10'd1,    16'sh0000, 16'sh7FFF, 1'b0, 17'sd0},
    '{REQ_LOAD, 10'd512,  16'sh8000, 16'sh7FFF, 1'b0, 17'sd0},
    '{REQ_LOAD, 10'd511,  16'sh7FFF, 16'sh8000, 1'b0, 17'sd0},
    '{REQ_READ, 10'd1,    16'sh0000, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_READ, 10'd512,  16'sh0000, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_READ, 10'd1023, 16'sh0000, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_READ, 10'd256,  16'sh0000, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_LOAD, 10'd2,    16'sh7FFF, 16'sh7FFF, 1'b0, 17'sd0},
    '{REQ_LOAD, 10'd3,    16'sh8000, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_READ, 10'd3,    16'sh0000, 16'sh0000, 1'b0, 17'sd0},
    '{REQ_READ, 10'd0,    16'sh0000, 16'sh0000, 1'b0, 17'sd0}
  };

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    req_type;
  logic [PTS_W-1:0]        position;
  logic signed [SMP_W-1:0] sample_re;
  logic signed [SMP_W-1:0] sample_im;
  logic                    done;
  logic [PTS_W-1:0]        out_position;
  logic signed [OUT_W-1:0] real_value;

  logic signed [SMP_W-1:0] store_re [POINTS];
  logic signed [SMP_W-1:0] store_im [POINTS];
  logic signed [SMP_W-1:0] cos_tab [POINTS];
  logic signed [SMP_W-1:0] sin_tab [POINTS];

  idft_output_t pending_outputs [$];
  int           errors = 0;
  int unsigned  cycles = 0;

  inverse_dft_real_part DUT (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [SMP_W-1:0] q30_to_q15(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return r[SMP_W-1:0];
  endfunction

  function automatic void build_twiddles();
    longint ph;
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    for (int m = 0; m < POINTS; m++) begin
      ph = ((longint'(m) <<< 32) + longint'(POINTS / 2)) / longint'(POINTS);
      z  = ph & 64'sh00000000FFFFFFFF;
      if (z >= HALF_TURN_Q) begin
        z = z - FULL_TURN_Q;
      end
      x    = ROT_GAIN_Q30;
      y    = 64'sd0;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
        z    = z - HALF_TURN_Q;
        flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z    = z + HALF_TURN_Q;
        flip = 1'b1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 64'sd0) begin
          x = x - dx;
          y = y + dy;
          z = z - cordic_arc[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + cordic_arc[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      cos_tab[m] = q30_to_q15(x);
      sin_tab[m] = q30_to_q15(y);
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] idft_real_at(logic [PTS_W-1:0] n);
    longint acc;
    longint q;
    int     m;
    acc = 64'sd0;
    for (int k = 0; k < POINTS; k++) begin
      m   = (k * int'(n)) % POINTS;
      acc = acc + longint'(store_re[k]) * longint'(cos_tab[m])
                - longint'(store_im[k]) * longint'(sin_tab[m]);
    end
    q = (acc + (64'sd1 <<< (PTS_W + 14))) >>> (PTS_W + 15);
    if (q > 64'sd65535) begin
      q = 64'sd65535;
    end
    if (q < -64'sd65536) begin
      q = -64'sd65536;
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    logic signed [SMP_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'sh7FFF;
      1: v = 16'sh8000;
      default: v = SMP_W'($urandom);
    endcase
    return v;
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer.
  task automatic put_request(input logic rt, input logic [PTS_W-1:0] pos,
                             input logic signed [SMP_W-1:0] re,
                             input logic signed [SMP_W-1:0] im,
                             input bit typed, input logic signed [OUT_W-1:0] typed_val,
                             input bit gaps);
    idft_output_t want;
    start     <= 1'b1;
    req_type  <= rt;
    position  <= pos;
    sample_re <= re;
    sample_im <= im;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    if (rt == REQ_READ) begin
      want.pos = pos;
      want.val = typed ? typed_val : idft_real_at(pos);
      pending_outputs.push_back(want);
    end else begin
      store_re[pos] = re;
      store_im[pos] = im;
    end
    @(negedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start     <= 1'b0;
      req_type  <= 1'($urandom);
      position  <= PTS_W'($urandom);
      sample_re <= SMP_W'($urandom);
      sample_im <= SMP_W'($urandom);
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : check_outputs
    idft_output_t want;
    if (!rst && done) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: out_position=%0d real_value=%0d",
               out_position, real_value);
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_position !== want.pos) begin
          $error("out_position: expected %0d, actual %0d", want.pos, out_position);
          errors++;
        end
        if (real_value !== want.val) begin
          $error("real_value: expected %0d, actual %0d", want.val, real_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** inverse_dft_real_part: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic                    rt;
    logic [PTS_W-1:0]        pos;
    logic signed [SMP_W-1:0] re;
    logic signed [SMP_W-1:0] im;
    rst       = 1'b1;
    start     = 1'b0;
    req_type  = REQ_LOAD;
    position  = '0;
    sample_re = '0;
    sample_im = '0;
    build_twiddles();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every read sums over the whole store, so all entries are written first.
    for (int k = 0; k < POINTS; k++) begin
      put_request(REQ_LOAD, k[PTS_W-1:0], 16'sh0000, 16'sh0000, 1'b0, '0, 1'b1);
    end

    foreach (directed[i]) begin
      put_request(directed[i].rt, directed[i].pos, directed[i].re, directed[i].im,
                  directed[i].typed, directed[i].val, 1'b1);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      rt = ($urandom_range(0, 6) == 0) ? REQ_READ : REQ_LOAD;
      case ($urandom_range(0, 9))
        0: pos = '0;
        1: pos = '1;
        default: pos = PTS_W'($urandom);
      endcase
      re = pick_sample();
      im = pick_sample();
      put_request(rt, pos, re, im, 1'b0, '0, i < RANDOM_ITEMS - CALM_TAIL);
    end
    start <= 1'b0;

    while (pending_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** inverse_dft_real_part: PASSED **");
    end else begin
      $display("** inverse_dft_real_part: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/idft_pkg.sv
rtl/core/idft_front.sv
rtl/core/idft_tw_rom.sv
rtl/core/idft_back.sv
rtl/core/inverse_dft_real_part.sv
tb/tb_inverse_dft_real_part.sv
